FILE: hdl/p31h_pkg.sv
// shared constants, register codes and the byte fold for the base-31 string hash
// no dependencies
`default_nettype none

package p31h_pkg;

  localparam int HASH_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 2'd2;

  localparam logic [HASH_W-1:0] SEED_RST      = 32'd12345;
  localparam logic [HASH_W-1:0] RANGE_MAX_RST = 32'd100;
  localparam logic [HASH_W-1:0] RANGE_MIN_RST = 32'd1;

  typedef logic [HASH_W-1:0] hash_t;

  // h*31 + sign-extended byte, modulo 2^32
  function automatic hash_t fold_byte(input hash_t h, input logic [BYTE_W-1:0] b);
    hash_t ext;
    hash_t times31;
    ext     = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    times31 = (h << 5) - h;
    return times31 + ext;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/p31h_div.sv
// iterative restoring divider, one remainder bit per cycle, remainder output only
// depends on nothing but its parameter
`default_nettype none

module p31h_div #(
  parameter int Width = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [Width-1:0] dividend,
  input  wire logic [Width-1:0] divisor,
  output logic                  done,
  output logic [Width-1:0]      remainder
);

  localparam int CntW = $clog2(Width + 1);
  localparam logic [CntW-1:0] Steps = CntW'(Width);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [Width-1:0]  rem_r, rem_nxt;
  logic [Width-1:0]  quo_r, quo_nxt;
  logic [Width-1:0]  dvs_r, dvs_nxt;
  logic [Width:0]    shifted;
  logic [Width:0]    trial;

  assign shifted = {rem_r, quo_r[Width-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = Steps;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = trial[Width] ? shifted[Width-1:0] : trial[Width-1:0];
      quo_nxt = quo_r << 1;
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: hdl/poly31_string_hash_range_top.sv
// base-31 polynomial string hash with range reduction, top level and sequencer
// depends on p31h_pkg and p31h_div
`default_nettype none

// usage:
//   in_*  carries one string byte per transfer; in_tlast marks the final byte.
//   out_* carries one result per string: the hash, reduced into
//   [range_min, range_max] when it falls outside, and a fault flag in
//   out_tuser when it falls outside and the modulus
//   range_max-range_min+1 wraps to zero.
//   cfg_* writes seed (index 0), range_max (1), range_min (2); the user
//   must do so only while idle, as the block does not enforce it.
// timing:
//   a byte without tlast is folded in the cycle it is accepted; in_tready
//   stays high, so such bytes stream at one per cycle.
//   a last byte passes ST_CHECK (bounds check), then, if reduction is
//   needed, ST_DIV in the restoring divider (one remainder bit per
//   cycle), then ST_EMIT, which loads the output register. in_tready is
//   low from the last byte's transfer until that load.
//   reset clears the handshake state, restores register defaults and
//   starts a new string. when out_tready is low the result waits in the
//   output register; a following string's bytes are still accepted, and
//   its last byte waits for the output register before it is delivered.
module poly31_string_hash_range_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [p31h_pkg::BYTE_W-1:0]   in_tdata,   // byte_value
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [p31h_pkg::HASH_W-1:0]        out_tdata,  // hash_value
  output logic                               out_tuser,  // divide_fault
  input  wire logic                          cfg_we,
  input  wire logic [p31h_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [p31h_pkg::HASH_W-1:0]   cfg_data
);

  import p31h_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  hash_t      seed_r, range_max_r, range_min_r;
  hash_t      hash_r, hash_nxt;
  logic       start_r, start_nxt;
  hash_t      res_r, res_nxt;
  logic       fault_r, fault_nxt;
  logic       out_vld_r, out_vld_nxt;
  hash_t      out_data_r, out_data_nxt;
  logic       out_fault_r, out_fault_nxt;

  logic       in_xfer;
  hash_t      modulus;
  logic       out_of_range;
  logic       div_start;
  logic       div_done;
  hash_t      div_rem;

  assign in_tready    = (state_r == ST_IDLE);
  assign in_xfer      = in_tvalid && in_tready;
  assign modulus      = range_max_r - range_min_r + hash_t'(1);
  assign out_of_range = (hash_r > range_max_r) || (hash_r < range_min_r);

  p31h_div #(
    .Width (HASH_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (hash_r),
    .divisor   (modulus),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    start_nxt     = start_r;
    res_nxt       = res_r;
    fault_nxt     = fault_r;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    out_fault_nxt = out_fault_r;
    div_start     = 1'b0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          hash_nxt  = fold_byte(start_r ? seed_r : hash_r, in_tdata);
          start_nxt = in_tlast;
          if (in_tlast) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        res_nxt   = hash_r;
        fault_nxt = 1'b0;
        if (!out_of_range) begin
          state_nxt = ST_EMIT;
        end else if (modulus == '0) begin
          fault_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_rem + range_min_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_data_nxt  = res_r;
          out_fault_nxt = fault_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b1;
      out_vld_r   <= 1'b0;
      seed_r      <= SEED_RST;
      range_max_r <= RANGE_MAX_RST;
      range_min_r <= RANGE_MIN_RST;
    end else begin
      state_r   <= state_nxt;
      start_r   <= start_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEED:      seed_r      <= cfg_data;
          REG_RANGE_MAX: range_max_r <= cfg_data;
          REG_RANGE_MIN: range_min_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hash_r      <= hash_nxt;
    res_r       <= res_nxt;
    fault_r     <= fault_nxt;
    out_data_r  <= out_data_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fault_r;

endmodule

`default_nettype wire
